>>> design/gpr_pkg.sv
// Shared types, register codes and field-mask helpers for the GPIO port register block.
`default_nettype none

package gpr_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned PINS_W = 16;
   localparam int unsigned LOCK_W = 17;

   // bus access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // word register codes
   localparam logic [3:0] REG_MODE    = 4'd0;
   localparam logic [3:0] REG_OTYPE   = 4'd1;
   localparam logic [3:0] REG_SPEED   = 4'd2;
   localparam logic [3:0] REG_PULL    = 4'd3;
   localparam logic [3:0] REG_IDR     = 4'd4;
   localparam logic [3:0] REG_ODR     = 4'd5;
   localparam logic [3:0] REG_BSRR    = 4'd6;
   localparam logic [3:0] REG_LOCK    = 4'd7;
   localparam logic [3:0] REG_AF_LOW  = 4'd8;
   localparam logic [3:0] REG_AF_HIGH = 4'd9;

   // bit 16 of the lock word: key bit on writes, lock flag once set
   localparam int unsigned LOCK_KEY_BIT = 16;

   // lock key sequence: idle, first 1 seen, then 0, then 1 (armed for the read)
   typedef enum logic [3:0] {
      SEQ_IDLE  = 4'b0001,
      SEQ_ONE   = 4'b0010,
      SEQ_ZERO  = 4'b0100,
      SEQ_ARMED = 4'b1000
   } lock_seq_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [PINS_W-1:0] out_levels;
      logic              lock_active;
   } rsp_type;

   // widen a per-pin mask to two bits per pin
   function automatic logic [DATA_W-1:0] expand2(input logic [PINS_W-1:0] pins);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < PINS_W; i++) begin
         m[2*i +: 2] = {2{pins[i]}};
      end
      return m;
   endfunction

   // widen eight pin bits to four bits per pin
   function automatic logic [DATA_W-1:0] expand4(input logic [7:0] pins);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         m[4*i +: 4] = {4{pins[i]}};
      end
      return m;
   endfunction

   // keep frozen fields, take the rest from data, drop unimplemented pins
   function automatic logic [DATA_W-1:0] masked_write(
      input logic [DATA_W-1:0] old_bits,
      input logic [DATA_W-1:0] data,
      input logic [DATA_W-1:0] keep,
      input logic [DATA_W-1:0] impl
   );
      return ((old_bits & keep) | (data & ~keep)) & impl;
   endfunction

endpackage

`default_nettype wire

>>> design/gpio_port_registers_top.sv
// GPIO port register block: one register bus access per item, registered result.
//
//   channel   ports                                           direction
//   req       req_valid/req_stall, op, reg_index, write_data,  in
//             pin_levels
//   rsp       rsp_valid/rsp_stall, read_data, out_levels,     out
//             lock_active
//
// The register update and the read mux sit between the request ports and the result
// register, so one item enters per clock while req_stall is low.
// A two-entry result buffer (result register plus skid) lets the block take an
// item while the previous result is stalled; req_stall rises only when both are full.
// Reset clears every port register, the lock state and both result valid flags.
`default_nettype none

module gpio_port_registers_top
   import gpr_pkg::*;
#(
   parameter int unsigned PIN_COUNT = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic [3:0]        req_reg_index,
   input  wire logic [DATA_W-1:0] req_write_data,
   input  wire logic [PINS_W-1:0] req_pin_levels,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DATA_W-1:0]      rsp_read_data,
   output logic [PINS_W-1:0]      rsp_out_levels,
   output logic                   rsp_lock_active
);

   localparam logic [PINS_W-1:0] PIN_MASK = PINS_W'((32'd1 << PIN_COUNT) - 32'd1);
   localparam logic [DATA_W-1:0] IMPL2    = expand2(PIN_MASK);
   localparam logic [DATA_W-1:0] IMPL4_LO = expand4(PIN_MASK[7:0]);
   localparam logic [DATA_W-1:0] IMPL4_HI = expand4(PIN_MASK[15:8]);

   logic [DATA_W-1:0] mode_ff, mode_in;
   logic [PINS_W-1:0] otype_ff, otype_in;
   logic [DATA_W-1:0] speed_ff, speed_in;
   logic [DATA_W-1:0] pull_ff, pull_in;
   logic [PINS_W-1:0] odr_ff, odr_in;
   logic [LOCK_W-1:0] lock_word_ff, lock_word_in;
   lock_seq_type      lock_seq_ff, lock_seq_in;
   logic [DATA_W-1:0] af_low_ff, af_low_in;
   logic [DATA_W-1:0] af_high_ff, af_high_in;

   rsp_type rsp_ff, rsp_in;
   rsp_type skid_ff, skid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type result;

   logic              accept;
   logic              locked;
   logic [PINS_W-1:0] frozen;
   logic [DATA_W-1:0] keep2;
   logic [PINS_W-1:0] lock_bits;
   logic              lock_key;
   logic              lock_same;
   logic [DATA_W-1:0] read_word;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;

   assign locked    = lock_word_ff[LOCK_KEY_BIT];
   assign frozen    = locked ? lock_word_ff[PINS_W-1:0] : '0;
   assign keep2     = expand2(frozen);
   assign lock_bits = req_write_data[PINS_W-1:0] & PIN_MASK;
   assign lock_key  = req_write_data[LOCK_KEY_BIT];
   assign lock_same = (lock_bits == lock_word_ff[PINS_W-1:0]);

   // register updates for the accepted item
   always_comb begin
      mode_in      = mode_ff;
      otype_in     = otype_ff;
      speed_in     = speed_ff;
      pull_in      = pull_ff;
      odr_in       = odr_ff;
      lock_word_in = lock_word_ff;
      lock_seq_in  = lock_seq_ff;
      af_low_in    = af_low_ff;
      af_high_in   = af_high_ff;
      if (accept && req_op == OP_WRITE) begin
         case (req_reg_index)
            REG_MODE:    mode_in  = masked_write(mode_ff, req_write_data, keep2, IMPL2);
            REG_OTYPE:   otype_in = (otype_ff & frozen) | (req_write_data[PINS_W-1:0]
                                    & ~frozen & PIN_MASK);
            REG_SPEED:   speed_in = masked_write(speed_ff, req_write_data, keep2, IMPL2);
            REG_PULL:    pull_in  = masked_write(pull_ff, req_write_data, keep2, IMPL2);
            REG_ODR:     odr_in   = req_write_data[PINS_W-1:0] & PIN_MASK;
            REG_BSRR:    odr_in   = ((odr_ff & ~req_write_data[DATA_W-1:PINS_W])
                                    | req_write_data[PINS_W-1:0]) & PIN_MASK;
            REG_LOCK: begin
               if (!locked) begin
                  if (lock_seq_ff == SEQ_ONE && !lock_key && lock_same) begin
                     lock_seq_in = SEQ_ZERO;
                  end else if (lock_seq_ff == SEQ_ZERO && lock_key && lock_same) begin
                     lock_seq_in = SEQ_ARMED;
                  end else begin
                     lock_seq_in = lock_key ? SEQ_ONE : SEQ_IDLE;
                  end
                  lock_word_in = {1'b0, lock_bits};
               end
            end
            REG_AF_LOW:  af_low_in  = masked_write(af_low_ff, req_write_data,
                                      expand4(frozen[7:0]), IMPL4_LO);
            REG_AF_HIGH: af_high_in = masked_write(af_high_ff, req_write_data,
                                      expand4(frozen[15:8]), IMPL4_HI);
            default: ;
         endcase
      end else if (accept && req_reg_index == REG_LOCK) begin
         // a lock read with the key sequence complete freezes the port
         if (lock_seq_ff == SEQ_ARMED && !locked) begin
            lock_word_in[LOCK_KEY_BIT] = 1'b1;
            lock_seq_in                = SEQ_IDLE;
         end
      end
   end

   // read mux; a lock read returns the word after any freeze
   always_comb begin
      read_word = '0;
      if (req_op == OP_READ) begin
         case (req_reg_index)
            REG_MODE:    read_word = mode_ff;
            REG_OTYPE:   read_word = {{(DATA_W-PINS_W){1'b0}}, otype_ff};
            REG_SPEED:   read_word = speed_ff;
            REG_PULL:    read_word = pull_ff;
            REG_IDR:     read_word = {{(DATA_W-PINS_W){1'b0}}, req_pin_levels & PIN_MASK};
            REG_ODR:     read_word = {{(DATA_W-PINS_W){1'b0}}, odr_ff};
            REG_LOCK:    read_word = {{(DATA_W-LOCK_W){1'b0}}, lock_word_in};
            REG_AF_LOW:  read_word = af_low_ff;
            REG_AF_HIGH: read_word = af_high_ff;
            default:     read_word = '0;
         endcase
      end
   end

   always_comb begin
      result.read_data   = read_word;
      result.out_levels  = odr_in;
      result.lock_active = lock_word_in[LOCK_KEY_BIT];
   end

   // result register with a skid entry behind it
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = result;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         otype_ff      <= '0;
         speed_ff      <= '0;
         pull_ff       <= '0;
         odr_ff        <= '0;
         lock_word_ff  <= '0;
         lock_seq_ff   <= SEQ_IDLE;
         af_low_ff     <= '0;
         af_high_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         otype_ff      <= otype_in;
         speed_ff      <= speed_in;
         pull_ff       <= pull_in;
         odr_ff        <= odr_in;
         lock_word_ff  <= lock_word_in;
         lock_seq_ff   <= lock_seq_in;
         af_low_ff     <= af_low_in;
         af_high_ff    <= af_high_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_out_levels  = rsp_ff.out_levels;
   assign rsp_lock_active = rsp_ff.lock_active;

`ifndef SYNTH
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds an item while the result register is empty");

   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      lock_word_ff[LOCK_KEY_BIT] |=> lock_word_ff[LOCK_KEY_BIT])
      else $error("port lock released without reset");

   a_locked_seq_idle: assert property (@(posedge clock) disable iff (reset)
      lock_word_ff[LOCK_KEY_BIT] |-> lock_seq_ff == SEQ_IDLE)
      else $error("lock key sequence moved after the port locked");

   a_stalled_accept_to_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("item accepted under a stalled result was not held in the skid entry");
`endif

endmodule

`default_nettype wire
